@@ design/cbh_pkg.sv @@
// ----------------------------------------------------------------------------
// cbh_pkg: shared types and constants for the cumulative bucket histogram
// Request/response payload structs, CSR write bundle, widths and helpers.
// ----------------------------------------------------------------------------
package cbh_pkg;

   // Bucket bank sizing: ACTIVE_BUCKETS active buckets out of MAX_SLOTS fields
   localparam int ACTIVE_BUCKETS = 8;   // 1..8
   localparam int MAX_SLOTS      = 8;

   localparam int SAMPLE_W    = 32;
   localparam int SUM_W       = 64;
   localparam int COUNT_W     = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // CSR map: bound_i sits at REG_BOUND_BASE + i
   localparam logic [CSR_INDEX_W-1:0] REG_BOUND_BASE = CSR_INDEX_W'(0);

   // Request modes
   localparam logic MODE_OBSERVE = 1'b0;
   localparam logic MODE_REPORT  = 1'b1;

   localparam logic [COUNT_W-1:0]         COUNT_MAX  = {COUNT_W{1'b1}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

   typedef logic [COUNT_W-1:0] count_type;
   typedef count_type [MAX_SLOTS-1:0] bucket_array_type;

   typedef struct packed {
      logic                       mode;
      logic signed [SAMPLE_W-1:0] sample;
   } cbh_req_type;

   typedef struct packed {
      logic        [COUNT_W-1:0]  total_count;
      logic signed [SUM_W-1:0]    total_sum;
      logic signed [SAMPLE_W-1:0] lowest;
      logic signed [SAMPLE_W-1:0] highest;
      logic        [COUNT_W-1:0]  bucket_count_0;
      logic        [COUNT_W-1:0]  bucket_count_1;
      logic        [COUNT_W-1:0]  bucket_count_2;
      logic        [COUNT_W-1:0]  bucket_count_3;
      logic        [COUNT_W-1:0]  bucket_count_4;
      logic        [COUNT_W-1:0]  bucket_count_5;
      logic        [COUNT_W-1:0]  bucket_count_6;
      logic        [COUNT_W-1:0]  bucket_count_7;
   } cbh_rsp_type;

   typedef struct packed {
      logic                   write_en;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
   } cbh_csr_wr_type;

   // Saturating increment
   function automatic count_type inc_sat(input count_type c);
      inc_sat = (c == COUNT_MAX) ? c : c + COUNT_W'(1);
   endfunction

endpackage

@@ design/cbh_bucket_bank.sv @@
// ----------------------------------------------------------------------------
// cbh_bucket_bank: bucket bounds and cumulative bucket counters
// Holds one bound register and one saturating counter per active bucket. All
// bounds are compared against the sample in parallel; the post-update counts
// come out combinationally for the response.
// ----------------------------------------------------------------------------
module cbh_bucket_bank (
   input  logic                          clock,
   input  logic                          reset,
   input  cbh_pkg::cbh_csr_wr_type       csr_wr,
   input  logic                          observe,
   input  logic signed [cbh_pkg::SAMPLE_W-1:0] sample,
   output cbh_pkg::bucket_array_type     count_next
);
   import cbh_pkg::*;

   genvar i;
   generate
      for (i = 0; i < MAX_SLOTS; i++) begin : g_slot
         if (i < ACTIVE_BUCKETS) begin : g_active
            logic signed [SAMPLE_W-1:0] bound_ff;
            count_type                  count_ff;
            count_type                  count_in;
            logic                       hit;

            // bound write from the CSR port
            always_ff @(posedge clock) begin
               if (reset) begin
                  bound_ff <= SAMPLE_MAX;
               end else if (csr_wr.write_en &&
                            csr_wr.index == REG_BOUND_BASE + CSR_INDEX_W'(i)) begin
                  bound_ff <= $signed(csr_wr.wdata[SAMPLE_W-1:0]);
               end
            end

            // cumulative less-or-equal bucket
            assign hit      = observe && (sample <= bound_ff);
            assign count_in = hit ? inc_sat(count_ff) : count_ff;

            always_ff @(posedge clock) begin
               if (reset) begin
                  count_ff <= '0;
               end else begin
                  count_ff <= count_in;
               end
            end

            assign count_next[i] = count_in;
         end else begin : g_unused
            assign count_next[i] = '0;
         end
      end
   endgenerate

endmodule

@@ design/cumulative_bucket_histogram.sv @@
// The result of an accepted request is registered in the response register, or in the skid
// register when that one is held. Throughput: one request per cycle while the skid register is
// empty; the running totals and all bucket compares update in a single pass between the request
// and the response register. A two-entry output (response register plus skid register) keeps
// req_ready high while one response waits on rsp_ready.
// Reset (synchronous): totals clear, minimum goes to the most positive value, bounds to max.
// ----------------------------------------------------------------------------
// cumulative_bucket_histogram: telemetry histogram with cumulative buckets
// Counts samples, keeps a saturating 64-bit sum, minimum, maximum and eight
// less-or-equal bucket counts; every request returns all totals.
// ----------------------------------------------------------------------------
module cumulative_bucket_histogram (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  cbh_pkg::cbh_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output cbh_pkg::cbh_rsp_type              rsp_data,
   input  logic                              csr_write_en,
   input  logic [cbh_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cbh_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import cbh_pkg::*;

   logic                       accept;
   logic                       observe;
   cbh_csr_wr_type             csr_wr;
   bucket_array_type           bucket_next;

   count_type                  count_ff, count_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0] low_ff, low_in;
   logic signed [SAMPLE_W-1:0] high_ff, high_in;
   logic signed [SUM_W:0]      sum_wide;

   cbh_rsp_type                result;
   logic                       out_valid_ff, out_valid_in;
   cbh_rsp_type                out_data_ff, out_data_in;
   logic                       skid_valid_ff, skid_valid_in;
   cbh_rsp_type                skid_data_ff, skid_data_in;

   // handshake
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign observe   = accept && (req_data.mode == MODE_OBSERVE);

   assign csr_wr = '{write_en: csr_write_en, index: csr_index, wdata: csr_wdata};

   // buckets
   cbh_bucket_bank u_bank (
      .clock      (clock),
      .reset      (reset),
      .csr_wr     (csr_wr),
      .observe    (observe),
      .sample     (req_data.sample),
      .count_next (bucket_next)
   );

   // saturating sum, one bit of headroom to detect overflow
   assign sum_wide = {sum_ff[SUM_W-1], sum_ff} +
                     {{(SUM_W-SAMPLE_W+1){req_data.sample[SAMPLE_W-1]}}, req_data.sample};

   // running totals next state
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      if (observe) begin
         count_in = inc_sat(count_ff);
         if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                     : {1'b0, {(SUM_W-1){1'b1}}};
         end else begin
            sum_in = sum_wide[SUM_W-1:0];
         end
         if (req_data.sample < low_ff) begin
            low_in = req_data.sample;
         end
         if (req_data.sample > high_ff) begin
            high_in = req_data.sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         low_ff   <= SAMPLE_MAX;
         high_ff  <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
      end
   end

   // response built from the updated totals
   always_comb begin
      result                = '0;
      result.total_count    = count_in;
      result.total_sum      = sum_in;
      result.lowest         = low_in;
      result.highest        = high_in;
      result.bucket_count_0 = bucket_next[0];
      result.bucket_count_1 = bucket_next[1];
      result.bucket_count_2 = bucket_next[2];
      result.bucket_count_3 = bucket_next[3];
      result.bucket_count_4 = bucket_next[4];
      result.bucket_count_5 = bucket_next[5];
      result.bucket_count_6 = bucket_next[6];
      result.bucket_count_7 = bucket_next[7];
   end

   // output register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = accept;
            out_data_in   = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ design/cbh_checker.sv @@
// ----------------------------------------------------------------------------
// cbh_checker: port-level checks for the cumulative bucket histogram
// Watches the request/response handshake and the consistency of the totals.
// ----------------------------------------------------------------------------
module cbh_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  cbh_pkg::cbh_rsp_type rsp_data
);
   import cbh_pkg::*;

   logic [1:0] pending_ff, pending_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // requests accepted but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_fire && rsp_fire) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // no response without an outstanding request
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without request");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // once any sample is seen, minimum is not above maximum
   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.total_count != '0 |->
         $signed(rsp_data.lowest) <= $signed(rsp_data.highest))
      else $error("lowest above highest");

   // no bucket counts more than the total
   a_bucket_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_data.bucket_count_0 <= rsp_data.total_count &&
         rsp_data.bucket_count_1 <= rsp_data.total_count &&
         rsp_data.bucket_count_2 <= rsp_data.total_count &&
         rsp_data.bucket_count_3 <= rsp_data.total_count &&
         rsp_data.bucket_count_4 <= rsp_data.total_count &&
         rsp_data.bucket_count_5 <= rsp_data.total_count &&
         rsp_data.bucket_count_6 <= rsp_data.total_count &&
         rsp_data.bucket_count_7 <= rsp_data.total_count)
      else $error("bucket count above total count");

endmodule

bind cumulative_bucket_histogram cbh_checker u_cbh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ tb/sv/cumulative_bucket_histogram_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cumulative_bucket_histogram_tb: self-checking bench for the bucket histogram
// Drives observe and report requests with random gaps and response stalls.
// An in-bench copy of the totals predicts every response, and each response
// is compared field by field in arrival order. Bucket bounds are rewritten
// between phases, including the extreme settings.
// ----------------------------------------------------------------------------
module cumulative_bucket_histogram_tb;
   import cbh_pkg::*;

   typedef logic signed [SAMPLE_W-1:0] bound_set_type [MAX_SLOTS];

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0]    SUM_MAX    = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0]    SUM_MIN    = {1'b1, {(SUM_W-1){1'b0}}};

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   cbh_req_type            req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   cbh_rsp_type            rsp_data;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Predicted histogram state and bound registers
   count_type                   obs_count = '0;
   logic signed [SUM_W-1:0]     sum_acc   = '0;
   logic signed [SAMPLE_W-1:0]  min_seen  = SAMPLE_MAX;
   logic signed [SAMPLE_W-1:0]  max_seen  = '0;
   count_type                   bucket_acc [MAX_SLOTS] = '{default: '0};
   logic signed [SAMPLE_W-1:0]  bound_cfg  [MAX_SLOTS] = '{default: SAMPLE_MAX};

   cbh_rsp_type expected_totals_q [$];
   int          error_count  = 0;
   bit          req_idle_on  = 1'b1;
   bit          rsp_stalls_on = 1'b1;

   cumulative_bucket_histogram u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // Advance the predicted totals by one request and return the response
   function automatic cbh_rsp_type update_totals(input cbh_req_type item);
      logic signed [SUM_W:0] wide;
      count_type             shown [MAX_SLOTS];
      cbh_rsp_type           r;
      if (item.mode == MODE_OBSERVE) begin
         if (obs_count != COUNT_MAX) obs_count = obs_count + COUNT_W'(1);
         // 65-bit add, clamp when the top two bits disagree
         wide = {sum_acc[SUM_W-1], sum_acc} + {{(SUM_W-SAMPLE_W+1){item.sample[SAMPLE_W-1]}},
                                               item.sample};
         if (wide[SUM_W] != wide[SUM_W-1]) sum_acc = wide[SUM_W] ? SUM_MIN : SUM_MAX;
         else sum_acc = wide[SUM_W-1:0];
         if (item.sample < min_seen) min_seen = item.sample;
         if (item.sample > max_seen) max_seen = item.sample;
         for (int i = 0; i < ACTIVE_BUCKETS; i++) begin
            if (item.sample <= bound_cfg[i] && bucket_acc[i] != COUNT_MAX)
               bucket_acc[i] = bucket_acc[i] + COUNT_W'(1);
         end
      end
      // Buckets past ACTIVE_BUCKETS always read zero
      for (int i = 0; i < MAX_SLOTS; i++) shown[i] = (i < ACTIVE_BUCKETS) ? bucket_acc[i] : '0;
      r.total_count    = obs_count;
      r.total_sum      = sum_acc;
      r.lowest         = min_seen;
      r.highest        = max_seen;
      r.bucket_count_0 = shown[0];
      r.bucket_count_1 = shown[1];
      r.bucket_count_2 = shown[2];
      r.bucket_count_3 = shown[3];
      r.bucket_count_4 = shown[4];
      r.bucket_count_5 = shown[5];
      r.bucket_count_6 = shown[6];
      r.bucket_count_7 = shown[7];
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   // Response side: random stall stretches, switched off for full-rate phases
   initial begin
      int hold;
      hold = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_stalls_on && $urandom_range(0, 3) == 0) hold = pick_gap_len();
         end
      end
   end

   // Response checker; handshake sampled mid-cycle, taken at the next edge
   initial begin
      cbh_rsp_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (expected_totals_q.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = expected_totals_q.pop_front();
               check_field("total_count",    want.total_count,    rsp_data.total_count);
               check_field("total_sum",      want.total_sum,      rsp_data.total_sum);
               check_field("lowest",         want.lowest,         rsp_data.lowest);
               check_field("highest",        want.highest,        rsp_data.highest);
               check_field("bucket_count_0", want.bucket_count_0, rsp_data.bucket_count_0);
               check_field("bucket_count_1", want.bucket_count_1, rsp_data.bucket_count_1);
               check_field("bucket_count_2", want.bucket_count_2, rsp_data.bucket_count_2);
               check_field("bucket_count_3", want.bucket_count_3, rsp_data.bucket_count_3);
               check_field("bucket_count_4", want.bucket_count_4, rsp_data.bucket_count_4);
               check_field("bucket_count_5", want.bucket_count_5, rsp_data.bucket_count_5);
               check_field("bucket_count_6", want.bucket_count_6, rsp_data.bucket_count_6);
               check_field("bucket_count_7", want.bucket_count_7, rsp_data.bucket_count_7);
            end
         end
      end
   end

   // Send one request; called at a rising edge, leaves valid high on return
   // so a back-to-back request needs no extra assignment in the same step.
   task automatic send_request(input logic mode, input logic signed [SAMPLE_W-1:0] sample);
      int          gap;
      cbh_req_type item;
      gap = req_idle_on ? pick_gap_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.mode   = mode;
      item.sample = sample;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(negedge clock); while (req_ready !== 1'b1);
      expected_totals_q.push_back(update_totals(item));
      @(posedge clock);
   endtask

   // Drop valid and wait for every outstanding response
   task automatic settle_pending();
      req_valid <= 1'b0;
      while (expected_totals_q.size() != 0) @(posedge clock);
   endtask

   // Rewrite all bounds back to back while the block is idle
   task automatic write_bounds(input bound_set_type vals);
      settle_pending();
      for (int i = 0; i < MAX_SLOTS; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= REG_BOUND_BASE + CSR_INDEX_W'(i);
         csr_wdata    <= vals[i];
         @(posedge clock);
         bound_cfg[i] = vals[i];
      end
      csr_write_en <= 1'b0;
   endtask

   // Mostly observe, some report; samples at extremes, next to bounds,
   // near zero or anywhere. Every so often the sender waits for a full drain.
   task automatic random_traffic(input int n);
      logic signed [SAMPLE_W-1:0] s;
      logic                       m;
      repeat (n) begin
         case ($urandom_range(0, 9))
            0:       s = SAMPLE_MIN;
            1:       s = SAMPLE_MAX;
            2, 3:    s = bound_cfg[$urandom_range(0, MAX_SLOTS-1)]
                         + (int'($urandom_range(0, 2)) - 1);
            4, 5:    s = int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            default: s = $urandom;
         endcase
         m = ($urandom_range(0, 9) == 0) ? MODE_REPORT : MODE_OBSERVE;
         if ($urandom_range(0, 79) == 0) settle_pending();
         send_request(m, s);
      end
   endtask

   // Report before any sample: zero totals, lowest at the top of the range
   task automatic test_totals_before_samples();
      send_request(MODE_REPORT, '0);
      send_request(MODE_REPORT, SAMPLE_MIN);
   endtask

   // Reset bounds are all max; a negative sample first keeps highest at zero
   task automatic test_sample_extremes();
      send_request(MODE_OBSERVE, -32'sd1);
      send_request(MODE_OBSERVE, SAMPLE_MIN);
      send_request(MODE_OBSERVE, '0);
      send_request(MODE_OBSERVE, SAMPLE_MAX);
      send_request(MODE_OBSERVE, 32'sd1);
      send_request(MODE_REPORT, SAMPLE_MAX);
   endtask

   // Samples equal to each bound and just past several of them
   task automatic test_bound_edges();
      bound_set_type b;
      b = '{SAMPLE_MIN, SAMPLE_MIN + 1, -32'sd1, 32'sd0, 32'sd1, 32'sh0001_0000,
            SAMPLE_MAX - 1, SAMPLE_MAX};
      write_bounds(b);
      send_request(MODE_OBSERVE, SAMPLE_MIN);
      send_request(MODE_OBSERVE, SAMPLE_MIN + 1);
      send_request(MODE_OBSERVE, -32'sd1);
      send_request(MODE_OBSERVE, 32'sd0);
      send_request(MODE_OBSERVE, 32'sd1);
      send_request(MODE_OBSERVE, 32'sh0001_0000);
      send_request(MODE_OBSERVE, 32'sh0001_0001);
      send_request(MODE_OBSERVE, SAMPLE_MAX - 1);
      send_request(MODE_OBSERVE, SAMPLE_MAX);
      send_request(MODE_REPORT, '0);
   endtask

   task automatic test_ascending_bounds();
      int            picks [$];
      bound_set_type b;
      repeat (MAX_SLOTS) picks.push_back(int'($urandom));
      picks.sort();
      foreach (b[i]) b[i] = picks[i];
      write_bounds(b);
      random_traffic(205);
   endtask

   // No gaps on either side for a whole phase
   task automatic test_unsorted_full_rate();
      bound_set_type b;
      foreach (b[i]) b[i] = $urandom;
      write_bounds(b);
      req_idle_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      random_traffic(205);
      settle_pending();
      req_idle_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // Only a sample at the very bottom counts
   task automatic test_lowest_bounds();
      bound_set_type b;
      b = '{default: SAMPLE_MIN};
      write_bounds(b);
      random_traffic(205);
   endtask

   task automatic test_highest_bounds();
      bound_set_type b;
      b = '{default: SAMPLE_MAX};
      write_bounds(b);
      random_traffic(205);
   endtask

   task automatic test_mixed_bounds();
      bound_set_type b;
      b = '{SAMPLE_MIN, SAMPLE_MAX, 32'sd0, -32'sd1, 32'sd1, $urandom, $urandom,
            32'sh0001_0000};
      write_bounds(b);
      random_traffic(205);
   endtask

   // Bounds 0x10000 apart around zero, where the small samples land
   task automatic test_near_zero_bounds();
      bound_set_type b;
      foreach (b[i]) b[i] = (i * 32'sh0001_0000) - 32'sh0003_0000;
      write_bounds(b);
      random_traffic(205);
   endtask

   initial begin
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_totals_before_samples();
      test_sample_extremes();
      test_bound_edges();
      test_ascending_bounds();
      test_unsorted_full_rate();
      test_lowest_bounds();
      test_highest_bounds();
      test_mixed_bounds();
      test_near_zero_bounds();

      settle_pending();
      // keep the clock running to catch any stray response
      repeat (8) @(posedge clock);
      if (expected_totals_q.size() != 0) begin
         $error("%0d responses never arrived", expected_totals_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("cumulative_bucket_histogram_tb: clean");
      end else begin
         $display("cumulative_bucket_histogram_tb: errors");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #10_000_000;
      $display("cumulative_bucket_histogram_tb: errors");
      $finish;
   end

endmodule

@@ cumulative_bucket_histogram.f @@
design/cbh_pkg.sv
design/cbh_bucket_bank.sv
design/cumulative_bucket_histogram.sv
design/cbh_checker.sv
tb/sv/cumulative_bucket_histogram_tb.sv
